[rtl/fmsk_pkg.sv]
// ----------------------------------------------------------------------------
// fmsk_pkg
// Types, codes and word-level bit counting functions for the sketch
// bitmap store and its scan unit.
// ----------------------------------------------------------------------------
package fmsk_pkg;

	localparam int COUNT_W  = 9;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_SKETCH = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_BIT    = 2'd2;

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_SKETCH_COUNT = 1'b0;
	localparam logic REG_SKETCH_WORDS = 1'b1;

	localparam logic [6:0] SKETCH_COUNT_RESET = 7'd64;
	localparam logic [3:0] SKETCH_WORDS_RESET = 4'd1;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_CALC  = 8'b0000_0100,
		ST_RD    = 8'b0000_1000,
		ST_WR    = 8'b0001_0000,
		ST_SCAN  = 8'b0010_0000,
		ST_DRAIN = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic start;
		logic valid;
	} scan_ctl_t;

	// Trailing zeros of a nonzero word by a five-step binary search.
	function automatic logic [4:0] ctz32(input logic [31:0] v);
		logic [31:0] x;
		logic [4:0]  n;
		x = v;
		n = '0;
		if (x[15:0] == '0) begin
			n[4] = 1'b1;
			x = x >> 16;
		end
		if (x[7:0] == '0) begin
			n[3] = 1'b1;
			x = x >> 8;
		end
		if (x[3:0] == '0) begin
			n[2] = 1'b1;
			x = x >> 4;
		end
		if (x[1:0] == '0) begin
			n[1] = 1'b1;
			x = x >> 2;
		end
		if (x[0] == 1'b0) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

	// Leading ones of a word that is not all ones: the trailing zeros of
	// the inverted word read in reverse bit order.
	function automatic logic [4:0] clo32(input logic [31:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = ~v[31-i];
		end
		return ctz32(r);
	endfunction

endpackage

[rtl/fm_sketch_bitmap_store.sv]
// ----------------------------------------------------------------------------
// fm_sketch_bitmap_store
// Array of distinct-count sketch bitmaps: set one bit of a sketch or query
// it, and report its trailing-zero and leading-one counts.
// ----------------------------------------------------------------------------
// A set word reads, updates and writes back its word before the sketch is
// scanned; a query or a refused set is only scanned, and an out-of-range
// sketch goes straight to the result. A new word is accepted in the cycle
// after the result is loaded into the output register, so the store takes
// one word at a time. The sketch is read one word per cycle through the
// single RAM read port. After reset a clearing pass zeroes the store;
// s_tready stays low until it ends. Config writes are always taken.
module fm_sketch_bitmap_store #(
	parameter int MAX_SKETCHES     = 64,
	parameter int MAX_SKETCH_WORDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [5:0] sketch_index, [13:6] bit_index, [15:14] zero
	input  logic        s_tuser,   // [0] op
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [8:0] trailing_zeros, [17:9] leading_ones, [23:18] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int DEPTH = MAX_SKETCHES * MAX_SKETCH_WORDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW    = $clog2(MAX_SKETCH_WORDS + 1);
	localparam int CW    = $clog2(MAX_SKETCH_WORDS * 32 + 1);

	fmsk_pkg::state_t state_q;

	logic [6:0]  sketch_count_q;
	logic [3:0]  sketch_words_q;
	logic [WW-1:0] eff_w;

	logic        op_q;
	logic [5:0]  idx_q;
	logic [7:0]  bit_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] waddr_q;
	logic [AW-1:0] clr_q;
	logic [WW-1:0] k_q;
	logic [fmsk_pkg::STATUS_W-1:0] status_q;

	logic        rv_s1;
	logic [WW-1:0] below_s1;

	logic        m_tvalid_q;
	logic [fmsk_pkg::COUNT_W-1:0] tz_out_q;
	logic [fmsk_pkg::COUNT_W-1:0] lo_out_q;
	logic [fmsk_pkg::STATUS_W-1:0] status_out_q;

	logic        idx_bad;
	logic        bit_bad;
	logic [AW-1:0] set_off;
	logic        out_free;

	logic        ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [31:0] ram_rdata;

	fmsk_pkg::scan_ctl_t scan_ctl;
	logic [CW-1:0] scan_tz;
	logic [CW-1:0] scan_lo;

	// Effective sketch size in words, with zero read as one and larger values capped at MAX_SKETCH_WORDS.
	always_comb begin
		if (sketch_words_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(sketch_words_q) > MAX_SKETCH_WORDS) begin
			eff_w = WW'(MAX_SKETCH_WORDS);
		end else begin
			eff_w = WW'(sketch_words_q);
		end
	end

	assign idx_bad = ({1'b0, idx_q} >= sketch_count_q) || (32'(idx_q) >= MAX_SKETCHES);
	assign bit_bad = 32'(bit_q) >= (32'(eff_w) << 5);
	// Words are stored most significant first within a sketch.
	assign set_off = AW'(eff_w) - AW'(1) - AW'(bit_q[7:5]);
	assign out_free = !m_tvalid_q || m_tready;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == fmsk_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sketch_count_q <= fmsk_pkg::SKETCH_COUNT_RESET;
			sketch_words_q <= fmsk_pkg::SKETCH_WORDS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fmsk_pkg::REG_SKETCH_COUNT: sketch_count_q <= cfg_data;
				fmsk_pkg::REG_SKETCH_WORDS: sketch_words_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fmsk_pkg::ST_CLEAR;
			clr_q      <= '0;
			rv_s1      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rv_s1 <= (state_q == fmsk_pkg::ST_SCAN);
			if (state_q == fmsk_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				fmsk_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= fmsk_pkg::ST_IDLE;
					end
				end
				fmsk_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= fmsk_pkg::ST_CALC;
					end
				end
				fmsk_pkg::ST_CALC: begin
					if (idx_bad) begin
						state_q <= fmsk_pkg::ST_DONE;
					end else if (op_q == fmsk_pkg::OP_SET && !bit_bad) begin
						state_q <= fmsk_pkg::ST_RD;
					end else begin
						state_q <= fmsk_pkg::ST_SCAN;
					end
				end
				fmsk_pkg::ST_RD: begin
					state_q <= fmsk_pkg::ST_WR;
				end
				fmsk_pkg::ST_WR: begin
					state_q <= fmsk_pkg::ST_SCAN;
				end
				fmsk_pkg::ST_SCAN: begin
					if (k_q == eff_w - WW'(1)) begin
						state_q <= fmsk_pkg::ST_DRAIN;
					end
				end
				fmsk_pkg::ST_DRAIN: begin
					state_q <= fmsk_pkg::ST_DONE;
				end
				fmsk_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= fmsk_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fmsk_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		below_s1 <= eff_w - WW'(1) - k_q;
		case (state_q)
			fmsk_pkg::ST_IDLE: begin
				op_q  <= s_tuser;
				idx_q <= s_tdata[5:0];
				bit_q <= s_tdata[13:6];
			end
			fmsk_pkg::ST_CALC: begin
				base_q <= AW'(idx_q) * AW'(eff_w);
				k_q    <= '0;
				if (idx_bad) begin
					status_q <= fmsk_pkg::STATUS_BAD_SKETCH;
				end else if (op_q == fmsk_pkg::OP_SET && bit_bad) begin
					status_q <= fmsk_pkg::STATUS_BAD_BIT;
				end else begin
					status_q <= fmsk_pkg::STATUS_OK;
				end
			end
			fmsk_pkg::ST_RD: begin
				waddr_q <= base_q + set_off;
			end
			fmsk_pkg::ST_SCAN: begin
				k_q <= k_q + WW'(1);
			end
			fmsk_pkg::ST_DONE: begin
				if (out_free) begin
					status_out_q <= status_q;
					if (status_q == fmsk_pkg::STATUS_BAD_SKETCH) begin
						tz_out_q <= '0;
						lo_out_q <= '0;
					end else begin
						tz_out_q <= fmsk_pkg::COUNT_W'(scan_tz);
						lo_out_q <= fmsk_pkg::COUNT_W'(scan_lo);
					end
				end
			end
			default: ;
		endcase
	end

	// The clearing pass and the set update share the write port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = waddr_q;
		ram_wdata = ram_rdata | (32'd1 << bit_q[4:0]);
		ram_raddr = base_q + AW'(k_q);
		case (state_q)
			fmsk_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			fmsk_pkg::ST_RD: begin
				ram_raddr = base_q + set_off;
			end
			fmsk_pkg::ST_WR: begin
				ram_we = 1'b1;
			end
			default: ;
		endcase
	end

	fmsk_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign scan_ctl.start = (state_q == fmsk_pkg::ST_CALC);
	assign scan_ctl.valid = rv_s1;

	fmsk_scan #(
		.MAX_SKETCH_WORDS (MAX_SKETCH_WORDS)
	) u_scan (
		.clk    (clk),
		.ctl    (scan_ctl),
		.word   (ram_rdata),
		.below  (below_s1),
		.size_w (eff_w),
		.tz     (scan_tz),
		.lo     (scan_lo)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, lo_out_q, tz_out_q};
	assign m_tuser  = status_out_q;

endmodule

[rtl/fmsk_ram.sv]
// ----------------------------------------------------------------------------
// fmsk_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fmsk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/fmsk_scan.sv]
// ----------------------------------------------------------------------------
// fmsk_scan
// Takes the words of one sketch, most significant word first, one word per
// cycle, and accumulates the trailing-zero and leading-one counts.
// ----------------------------------------------------------------------------
module fmsk_scan #(
	parameter int MAX_SKETCH_WORDS = 8
) (
	input  logic                                        clk,
	input  fmsk_pkg::scan_ctl_t                         ctl,
	input  logic [31:0]                                 word,
	input  logic [$clog2(MAX_SKETCH_WORDS+1)-1:0]       below,
	input  logic [$clog2(MAX_SKETCH_WORDS+1)-1:0]       size_w,
	output logic [$clog2(MAX_SKETCH_WORDS*32+1)-1:0]    tz,
	output logic [$clog2(MAX_SKETCH_WORDS*32+1)-1:0]    lo
);

	localparam int CW = $clog2(MAX_SKETCH_WORDS*32+1);

	logic [CW-1:0] tz_q;
	logic [CW-1:0] lo_q;
	logic          lo_done_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			tz_q      <= CW'(size_w) << 5;
			lo_q      <= '0;
			lo_done_q <= 1'b0;
		end else if (ctl.valid) begin
			// Words arrive top first, so the last nonzero word seen is the
			// lowest one and sets the trailing count.
			if (word != '0) begin
				tz_q <= (CW'(below) << 5) + CW'(fmsk_pkg::ctz32(word));
			end
			if (!lo_done_q) begin
				if (&word) begin
					lo_q <= lo_q + CW'(32);
				end else begin
					lo_q      <= lo_q + CW'(fmsk_pkg::clo32(word));
					lo_done_q <= 1'b1;
				end
			end
		end
	end

	assign tz = tz_q;
	assign lo = lo_q;

endmodule
